// File: hw/rtl/fltw_pkg.sv
// ----------------------------------------------------------------------------
// fltw_pkg - shared types for the four-level page table walker
// Word layouts, walk states, command codes and queue status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fltw_pkg;

	// input word function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_ENTRY = 1'b1;

	// result kinds and status codes
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;
	localparam logic STAT_OK          = 1'b0;
	localparam logic STAT_NOT_PRESENT = 1'b1;

	// table level whose entry a read request fetches
	localparam logic [1:0] LEVEL_TOP     = 2'd0;
	localparam logic [1:0] LEVEL_DIR_PTR = 2'd1;
	localparam logic [1:0] LEVEL_DIR     = 2'd2;
	localparam logic [1:0] LEVEL_TABLE   = 2'd3;

	// command queue geometry (depth is a power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		PS_4K = 2'd0,
		PS_2M = 2'd1,
		PS_1G = 2'd2
	} page_size_t;

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_TOP,
		WS_DIR_PTR,
		WS_DIR,
		WS_TABLE
	} walk_state_t;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_FAULT,
		CMD_LEAF
	} cmd_op_t;

	typedef struct packed {
		logic        func;
		logic [63:0] root;
		logic [47:0] linear;
		logic [63:0] read_data;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [51:0] read_address;
		logic        status;
		logic [63:0] entry;
		logic [51:0] phys_address;
		logic [1:0]  page_size;
	} out_word_t;

	// work handed from front to back
	typedef struct packed {
		cmd_op_t     op;
		logic [1:0]  level;   // table level of the entry to request
		page_size_t  psize;   // frame size of a leaf
		logic [63:0] data;    // root register or entry just read
		logic [47:0] linear;
	} cmd_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage

// File: hw/rtl/fltw_front.sv
// ----------------------------------------------------------------------------
// fltw_front - walk tracker
// Accepts input words, follows the walk level and queues one command per
// word that yields a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fltw_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  fltw_pkg::in_word_t item,
	input  logic             q_full,
	output logic             item_stall,
	output logic             push,
	output fltw_pkg::cmd_t   push_cmd
);
	import fltw_pkg::*;

	walk_state_t state_q, state_d;
	logic [47:0] held_linear_q;
	logic        accept;
	logic        is_start;
	logic        present;
	logic        page_bit;

	assign item_stall = q_full;
	assign accept     = item_valid & ~q_full;
	assign is_start   = (item.func == FUNC_START);
	assign present    = item.read_data[0];
	assign page_bit   = item.read_data[7];

	always_comb begin
		state_d = state_q;
		if (accept) begin
			case (state_q)
				WS_IDLE: if (is_start) state_d = WS_TOP;
				WS_TOP: if (!is_start) state_d = present ? WS_DIR_PTR : WS_IDLE;
				WS_DIR_PTR: if (!is_start) state_d = (present && !page_bit) ? WS_DIR : WS_IDLE;
				WS_DIR: if (!is_start) state_d = (present && !page_bit) ? WS_TABLE : WS_IDLE;
				WS_TABLE: if (!is_start) state_d = WS_IDLE;
				default: state_d = WS_IDLE;
			endcase
		end
	end

	always_comb begin
		push            = 1'b0;
		push_cmd.op     = CMD_READ;
		push_cmd.level  = LEVEL_TOP;
		push_cmd.psize  = PS_4K;
		push_cmd.data   = (state_q == WS_IDLE) ? item.root : item.read_data;
		push_cmd.linear = (state_q == WS_IDLE) ? item.linear : held_linear_q;
		if (accept) begin
			case (state_q)
				WS_IDLE: push = is_start;
				WS_TOP: begin
					push           = !is_start;
					push_cmd.level = LEVEL_DIR_PTR;
				end
				WS_DIR_PTR: begin
					push           = !is_start;
					push_cmd.level = LEVEL_DIR;
					if (page_bit) begin
						push_cmd.op    = CMD_LEAF;
						push_cmd.psize = PS_1G;
					end
				end
				WS_DIR: begin
					push           = !is_start;
					push_cmd.level = LEVEL_TABLE;
					if (page_bit) begin
						push_cmd.op    = CMD_LEAF;
						push_cmd.psize = PS_2M;
					end
				end
				WS_TABLE: begin
					push        = !is_start;
					push_cmd.op = CMD_LEAF;
				end
				default: push = 1'b0;
			endcase
			// a not-present entry ends the walk at any level
			if (state_q != WS_IDLE && !present) push_cmd.op = CMD_FAULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && state_q == WS_IDLE && is_start) begin
			held_linear_q <= item.linear;
		end
	end

endmodule

// File: hw/rtl/fltw_queue.sv
// ----------------------------------------------------------------------------
// fltw_queue - command queue
// Small FIFO between walk tracker and result builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fltw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fltw_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output fltw_pkg::cmd_t      pop_cmd,
	output fltw_pkg::q_status_t status
);
	import fltw_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_cmd      = slot_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: hw/rtl/fltw_back.sv
// ----------------------------------------------------------------------------
// fltw_back - result builder
// Turns queued commands into read requests or walk results, with an
// output register toward the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fltw_back #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  fltw_pkg::cmd_t     pop_cmd,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output fltw_pkg::out_word_t result
);
	import fltw_pkg::*;

	localparam logic [63:0] PHYS_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
	localparam logic [63:0] BASE12    = PHYS_MASK & ~((64'd1 << 12) - 64'd1);
	localparam logic [63:0] BASE21    = PHYS_MASK & ~((64'd1 << 21) - 64'd1);
	localparam logic [63:0] BASE30    = PHYS_MASK & ~((64'd1 << 30) - 64'd1);

	logic        valid_q;
	out_word_t   result_q;
	out_word_t   word_d;
	logic [8:0]  index;
	logic [63:0] table_base;

	assign pop          = !q_empty && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = result_q;
	assign table_base   = pop_cmd.data & BASE12;

	always_comb begin
		unique case (pop_cmd.level)
			LEVEL_TOP:     index = pop_cmd.linear[47:39];
			LEVEL_DIR_PTR: index = pop_cmd.linear[38:30];
			LEVEL_DIR:     index = pop_cmd.linear[29:21];
			LEVEL_TABLE:   index = pop_cmd.linear[20:12];
			default:       index = pop_cmd.linear[20:12];
		endcase
	end

	always_comb begin
		word_d.kind         = KIND_DONE;
		word_d.read_address = '0;
		word_d.status       = STAT_OK;
		word_d.entry        = pop_cmd.data;
		word_d.phys_address = '0;
		word_d.page_size    = PS_4K;
		unique case (pop_cmd.op)
			CMD_READ: begin
				word_d.kind         = KIND_READ;
				word_d.read_address = table_base[51:0] | {40'd0, index, 3'd0};
				// the request made by a start carries no entry
				if (pop_cmd.level == LEVEL_TOP) word_d.entry = '0;
			end
			CMD_FAULT: word_d.status = STAT_NOT_PRESENT;
			CMD_LEAF: begin
				word_d.page_size = pop_cmd.psize;
				unique case (pop_cmd.psize)
					PS_1G: word_d.phys_address = (pop_cmd.data[51:0] & BASE30[51:0])
						| {22'd0, pop_cmd.linear[29:0]};
					PS_2M: word_d.phys_address = (pop_cmd.data[51:0] & BASE21[51:0])
						| {31'd0, pop_cmd.linear[20:0]};
					default: word_d.phys_address = table_base[51:0]
						| {40'd0, pop_cmd.linear[11:0]};
				endcase
			end
			default: word_d.kind = KIND_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) result_q <= word_d;
	end

endmodule

// File: hw/rtl/four_level_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top - x86-64 four-level page table walker
// Starts walks, issues entry read requests and reports the final frame.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | word
//  ---------+----------------------------+---------------------------------
//  item     | item_valid / item_stall    | func, root, linear, read_data
//  result   | result_valid / result_stall| kind, read_address, status,
//           |                            | entry, phys_address, page_size
//
//  Flow: one word per cycle while the command queue is not full; a word that
//  yields a result is written into the command queue at its accepting edge
//  and moves into the output register when the back pops it, so the result
//  passes the queue slot and then the output register before it is offered.
//  Reset: arst_n clears the walk state, queue pointers and output valid;
//  the block is ready right after reset.
//  Stalls: item_stall rises when the two-entry command queue is full, which
//  only happens while result_stall holds the output register.
//
`timescale 1ns / 1ps

module four_level_page_table_walker_top #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  fltw_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output fltw_pkg::out_word_t result
);
	import fltw_pkg::*;

	// front -> queue
	logic      q_push;
	cmd_t      push_cmd;
	// queue -> back
	logic      q_pop;
	cmd_t      pop_cmd;
	q_status_t q_stat;

	// Front: tracks walk level, drops out-of-place words, queues commands.
	fltw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.q_full     (q_stat.full),
		.item_stall (item_stall),
		.push       (q_push),
		.push_cmd   (push_cmd)
	);

	// Decoupling queue so either side can stall on its own.
	fltw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.status   (q_stat)
	);

	// Back: address and frame arithmetic, registered result.
	fltw_back #(
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_stat.empty),
		.pop_cmd      (pop_cmd),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// queue occupancy stays within its depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("command queue overflow");

	// back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty command queue");

	// a fault command always carries an entry with the present bit clear
	a_fault_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && push_cmd.op == CMD_FAULT) |-> !push_cmd.data[0])
		else $error("fault queued for a present entry");

	// a popped command shows up as a valid result on the next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> result_valid)
		else $error("popped command did not reach output");

endmodule

// File: tb/tb_four_level_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_top - self-checking bench for the walker
// Sends start and table entry words and keeps its own model of the walk.
// Every result word is checked field by field, in order, against that model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_top;
	import fltw_pkg::*;

	localparam int PA_BITS      = 52;
	localparam int WALK_WORDS   = 580;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 20;
	localparam logic [63:0] PHYS_MASK = (64'd1 << PA_BITS) - 64'd1;

	// ------------------------------------------------------------------------
	// Walk tracker and result checker
	// ------------------------------------------------------------------------
	class walk_scoreboard;
		out_word_t   expected_words[$];
		bit          busy;
		logic [1:0]  level;
		logic [47:0] held_lin;
		int          failures;
		int          walks, faults, leaf_1g, leaf_2m, leaf_4k, ignored, checked;

		// table or frame base: entry bits PA_BITS-1 down to low
		function logic [51:0] frame_base(logic [63:0] v, int low);
			logic [63:0] keep;
			keep = PHYS_MASK & ~((64'd1 << low) - 64'd1);
			return 52'(v & keep);
		endfunction

		// 9-bit table index at the given linear address bit, times 8
		function logic [51:0] entry_offset(logic [47:0] lin, int low);
			logic [8:0] idx;
			idx = 9'(lin >> low);
			return {40'd0, idx, 3'd0};
		endfunction

		function void end_walk();
			busy  = 1'b0;
			level = LEVEL_TOP;
		endfunction

		// called on each accepted input word
		function void note_word(in_word_t w);
			out_word_t   o;
			logic [63:0] e;
			o = '0;
			e = w.read_data;
			if (w.func == FUNC_START) begin
				if (busy) begin
					ignored++;
					return;
				end
				held_lin = w.linear;
				busy     = 1'b1;
				level    = LEVEL_TOP;
				walks++;
				o.kind         = KIND_READ;
				o.read_address = frame_base(w.root, 12) | entry_offset(w.linear, 39);
			end else begin
				if (!busy) begin
					ignored++;
					return;
				end
				o.entry = e;
				if (!e[0]) begin
					end_walk();
					o.kind   = KIND_DONE;
					o.status = STAT_NOT_PRESENT;
					faults++;
				end else begin
					case (level)
						LEVEL_TOP: begin
							// large-page bit means nothing at the top level
							level          = LEVEL_DIR_PTR;
							o.read_address = frame_base(e, 12) | entry_offset(held_lin, 30);
						end
						LEVEL_DIR_PTR: begin
							if (e[7]) begin
								end_walk();
								o.kind         = KIND_DONE;
								o.phys_address = frame_base(e, 30) | {22'd0, held_lin[29:0]};
								o.page_size    = PS_1G;
								leaf_1g++;
							end else begin
								level          = LEVEL_DIR;
								o.read_address = frame_base(e, 12) | entry_offset(held_lin, 21);
							end
						end
						LEVEL_DIR: begin
							if (e[7]) begin
								end_walk();
								o.kind         = KIND_DONE;
								o.phys_address = frame_base(e, 21) | {31'd0, held_lin[20:0]};
								o.page_size    = PS_2M;
								leaf_2m++;
							end else begin
								level          = LEVEL_TABLE;
								o.read_address = frame_base(e, 12) | entry_offset(held_lin, 12);
							end
						end
						default: begin
							// last level: bit 7 ignored, always a 4 KiB frame
							end_walk();
							o.kind         = KIND_DONE;
							o.phys_address = frame_base(e, 12) | {40'd0, held_lin[11:0]};
							o.page_size    = PS_4K;
							leaf_4k++;
						end
					endcase
				end
			end
			expected_words.push_back(o);
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			if (failures <= 10)
				$display("  %s: expected %h, got %h", what, want, got);
		endfunction

		// called on each accepted result word
		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result word with nothing expected: %h", $time, got);
				return;
			end
			want = expected_words.pop_front();
			checked++;
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result word %0d mismatch", $time, checked);
				if (got.kind !== want.kind)
					flag("kind", 64'(want.kind), 64'(got.kind));
				if (got.read_address !== want.read_address)
					flag("read_address", 64'(want.read_address), 64'(got.read_address));
				if (got.status !== want.status)
					flag("status", 64'(want.status), 64'(got.status));
				if (got.entry !== want.entry)
					flag("entry", want.entry, got.entry);
				if (got.phys_address !== want.phys_address)
					flag("phys_address", 64'(want.phys_address), 64'(got.phys_address));
				if (got.page_size !== want.page_size)
					flag("page_size", 64'(want.page_size), 64'(got.page_size));
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and signals
	// ------------------------------------------------------------------------
	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_word_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	walk_scoreboard sb = new();
	int cycle_count = 0;
	int tx_calm = 0;
	int rx_calm = 0;

	four_level_page_table_walker_top #(
		.PHYS_ADDR_BITS(PA_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Idle lengths: mostly none or short, a few long, with calm stretches
	// where no idling happens at all.
	// ------------------------------------------------------------------------
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_word_t start_word(logic [63:0] root, logic [47:0] lin);
		in_word_t w;
		w.func      = FUNC_START;
		w.root      = root;
		w.linear    = lin;
		w.read_data = {$urandom, $urandom};   // don't-care, still toggled
		return w;
	endfunction

	function automatic in_word_t entry_word(logic [63:0] data);
		in_word_t w;
		w.func      = FUNC_ENTRY;
		w.root      = {$urandom, $urandom};
		w.linear    = 48'({$urandom, $urandom});
		w.read_data = data;
		return w;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random entry tuned to the level being fetched: mostly present, and the
	// page-size bit set often enough at the two levels where it ends a walk.
	function automatic in_word_t shaped_entry(logic [1:0] lvl);
		logic [63:0] d;
		d    = rand64();
		d[0] = ($urandom_range(0, 99) < 90);
		if (lvl == LEVEL_DIR_PTR || lvl == LEVEL_DIR)
			d[7] = ($urandom_range(0, 99) < 35);
		return entry_word(d);
	endfunction

	// ------------------------------------------------------------------------
	// Sender: word is changed at negedge, taken at posedge when not stalled
	// ------------------------------------------------------------------------
	task automatic send_word(input in_word_t w);
		int gap;
		@(negedge clk);
		item       = w;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_word(w);
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold off until every predicted result word has come back
	task automatic wait_drained();
		if (item_valid) begin
			@(negedge clk);
			item_valid = 1'b0;
		end
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		// entry while idle is dropped
		send_word(entry_word('1));
		// all-ones start, then a start while busy that must be dropped
		send_word(start_word('1, '1));
		send_word(start_word('0, '0));
		// top entry with page-size bit set keeps walking, full 4 KiB walk
		send_word(entry_word('1));
		send_word(entry_word(64'hFFFF_FFFF_FFFF_FF7F));
		send_word(entry_word(64'h0000_0000_0000_0001));
		// page-size bit at the last level still means a 4 KiB frame
		send_word(entry_word('1));
		// zero root and address, top entry not present
		send_word(start_word('0, '0));
		send_word(entry_word('0));
		// 1 GiB frame
		send_word(start_word(64'h000F_FFFF_FFFF_F000, 48'h8000_0000_0000));
		send_word(entry_word(64'h0000_0000_0000_0001));
		send_word(entry_word('1));
		// 2 MiB frame
		send_word(start_word(rand64(), 48'h7FFF_FFFF_FFFF));
		send_word(entry_word(64'h0000_0000_0000_0001));
		send_word(entry_word(64'hFFFF_FFFF_FFFF_FF7F));
		send_word(entry_word('1));
		// not present at the second level
		send_word(start_word(rand64(), 48'(rand64())));
		send_word(entry_word(rand64() | 64'h1));
		send_word(entry_word('0));
		// not present at the third level, page-size bit set but ignored
		send_word(start_word(rand64(), 48'(rand64())));
		send_word(entry_word(64'h1));
		send_word(entry_word(64'h1));
		send_word(entry_word(64'hFFFF_FFFF_FFFF_FFFE));
		// not present at the last level
		send_word(start_word(rand64(), 48'(rand64())));
		send_word(entry_word(64'h1));
		send_word(entry_word(64'h1));
		send_word(entry_word(64'h1));
		send_word(entry_word(64'h80));
	endtask

	// Mostly well-formed walks driven from the tracked walk level; the rest is
	// noise the block must drop (entries while idle, starts mid-walk).
	task automatic run_random();
		int sent;
		sent = 0;
		while (sent < WALK_WORDS) begin
			if (!sb.busy) begin
				if ($urandom_range(0, 99) < 8) begin
					send_word(entry_word(rand64()));
				end else begin
					send_word(start_word(rand64(), 48'(rand64())));
					sent++;
				end
			end else begin
				if ($urandom_range(0, 99) < 6) begin
					send_word(start_word(rand64(), 48'(rand64())));
				end else begin
					send_word(shaped_entry(sb.level));
					sent++;
				end
			end
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall changes at negedge, results taken at posedge
	// ------------------------------------------------------------------------
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = idle_len(rx_calm);
			if (n == 0) begin
				result_stall = 1'b0;
			end else begin
				result_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words outstanding",
				cycle_count, sb.expected_words.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb.level = LEVEL_TOP;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		// sender pause: let the result side empty completely
		wait_drained();
		run_random();

		@(negedge clk);
		item_valid = 1'b0;
		wait_drained();
		// catch any stray result words after the last expected one
		repeat (SETTLE_TICKS) @(posedge clk);
		sb.failures += sb.expected_words.size();

		$display("walks %0d: not present %0d, 1G %0d, 2M %0d, 4K %0d; dropped words %0d",
			sb.walks, sb.faults, sb.leaf_1g, sb.leaf_2m, sb.leaf_4k, sb.ignored);
		$display("result words checked %0d, failures %0d, cycles %0d",
			sb.checked, sb.failures, cycle_count);
		if (sb.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
